// ----- sv/dpsld_pkg.sv -----
// Shared types and constants for the dual-side PD drive unit.
package dpsld_pkg;

    localparam int POS_W      = 24;
    localparam int ERR_W      = POS_W + 1;
    localparam int DIF_W      = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int TMO_W      = 16;
    localparam int PWR_W      = 8;
    localparam int RAMP_W     = 7;
    localparam int LEEWAY_W   = 16;
    localparam int PROD_W     = DIF_W + GAIN_W + 1;
    localparam int FRAC_W     = 8;
    localparam int PWR_LIM    = 127;

    localparam int IN_DATA_W  = 4 * POS_W + 2 * GAIN_W + TMO_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 2 * PWR_W;
    localparam int OUT_USER_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_RAMP_STEP = 2'd0;
    localparam logic [1:0] REG_POWER_CAP = 2'd1;
    localparam logic [1:0] REG_LEEWAY    = 2'd2;

    localparam logic [RAMP_W-1:0]   RAMP_STEP_RST = 7'd10;
    localparam logic [RAMP_W-1:0]   POWER_CAP_RST = 7'd127;
    localparam logic [LEEWAY_W-1:0] LEEWAY_RST    = 16'd10;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic                    is_start;
        logic signed [POS_W-1:0] target_left;
        logic signed [POS_W-1:0] target_right;
        logic signed [POS_W-1:0] position_left;
        logic signed [POS_W-1:0] position_right;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_d;
        logic [TMO_W-1:0]        timeout_periods;
    } t_cmd;

    typedef struct packed {
        logic [RAMP_W-1:0]   ramp_step;
        logic [RAMP_W-1:0]   power_cap;
        logic [LEEWAY_W-1:0] leeway;
    } t_cfg;

    typedef struct packed {
        logic signed [PWR_W-1:0] power_left;
        logic signed [PWR_W-1:0] power_right;
        logic                    busy_res;
        logic                    settled;
        logic                    timed_out;
    } t_res;

endpackage

// ----- sv/dpsld_front.sv -----
// Input stage: takes stream items, decodes them into commands and registers them.
module dpsld_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [dpsld_pkg::IN_DATA_W-1:0] i_data,
    input  logic [dpsld_pkg::IN_USER_W-1:0] i_user,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output dpsld_pkg::t_cmd                 o_cmd
);
    import dpsld_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.is_start        = (i_user[0] == OP_START);
        n_cmd.target_left     = i_data[0*POS_W +: POS_W];
        n_cmd.target_right    = i_data[1*POS_W +: POS_W];
        n_cmd.position_left   = i_data[2*POS_W +: POS_W];
        n_cmd.position_right  = i_data[3*POS_W +: POS_W];
        n_cmd.gain_p          = i_data[4*POS_W +: GAIN_W];
        n_cmd.gain_d          = i_data[4*POS_W + GAIN_W +: GAIN_W];
        n_cmd.timeout_periods = i_data[4*POS_W + 2*GAIN_W +: TMO_W];
        n_valid = r_valid && !i_cmd_ready;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- sv/dpsld_queue.sv -----
// Short command queue between the decode stage and the control engine.
module dpsld_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dpsld_pkg::t_cmd i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dpsld_pkg::t_cmd o_data
);
    import dpsld_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/dpsld_back.sv -----
// Control engine: move state, end test, shared PD multipliers, slew and clamp, result register.
module dpsld_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dpsld_pkg::t_cfg i_cfg,
    input  logic            i_cmd_valid,
    input  dpsld_pkg::t_cmd i_cmd,
    output logic            o_cmd_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output dpsld_pkg::t_res o_res
);
    import dpsld_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_P = 3'd1;
    localparam logic [2:0] S_MUL_D = 3'd2;
    localparam logic [2:0] S_SAT   = 3'd3;
    localparam logic [2:0] S_DRIVE = 3'd4;

    localparam int SH_W = PROD_W - FRAC_W;

    function automatic logic signed [PWR_W-1:0] sat_power(input logic signed [PROD_W-1:0] s);
        logic signed [SH_W-1:0] q;
        q = s[PROD_W-1:FRAC_W];
        if (q > PWR_LIM) begin
            return PWR_W'(PWR_LIM);
        end else if (q < -PWR_LIM) begin
            return PWR_W'(-PWR_LIM);
        end
        return q[PWR_W-1:0];
    endfunction

    function automatic logic signed [PWR_W-1:0] slew(
        input logic signed [PWR_W-1:0] drive,
        input logic signed [PWR_W-1:0] goal,
        input logic [RAMP_W-1:0]       ramp,
        input logic [RAMP_W-1:0]       maxp
    );
        logic signed [PWR_W:0]   diff;
        logic signed [PWR_W:0]   rs;
        logic signed [PWR_W:0]   stp;
        logic signed [PWR_W+1:0] p;
        logic signed [PWR_W+1:0] mp;
        diff = {goal[PWR_W-1], goal} - {drive[PWR_W-1], drive};
        rs   = {{(PWR_W+1-RAMP_W){1'b0}}, ramp};
        mp   = {{(PWR_W+2-RAMP_W){1'b0}}, maxp};
        if (diff > rs) begin
            stp = rs;
        end else if (diff < -rs) begin
            stp = -rs;
        end else begin
            stp = diff;
        end
        p = {{2{drive[PWR_W-1]}}, drive} + {stp[PWR_W], stp};
        if (p > mp) begin
            p = mp;
        end else if (p < -mp) begin
            p = -mp;
        end
        return p[PWR_W-1:0];
    endfunction

    logic [2:0] r_state;
    logic [2:0] n_state;

    // move state
    logic signed [POS_W-1:0] r_goal_l, r_goal_r, n_goal_l, n_goal_r;
    logic signed [ERR_W-1:0] r_last_l, r_last_r, n_last_l, n_last_r;
    logic signed [PWR_W-1:0] r_drive_l, r_drive_r, n_drive_l, n_drive_r;
    logic [GAIN_W-1:0]       r_kp, r_kd, n_kp, n_kd;
    logic [TMO_W-1:0]        r_limit, r_elapsed, n_limit, n_elapsed;
    logic                    r_running, n_running;

    // tick working registers
    logic signed [ERR_W-1:0]  r_e_l, r_e_r, n_e_l, n_e_r;
    logic signed [DIF_W-1:0]  r_d_l, r_d_r, n_d_l, n_d_r;
    logic signed [PROD_W-1:0] r_prod_l, r_prod_r, n_prod_l, n_prod_r;
    logic signed [PROD_W-1:0] r_acc_l, r_acc_r, n_acc_l, n_acc_r;
    logic signed [PWR_W-1:0]  r_t_l, r_t_r, n_t_l, n_t_r;

    logic r_res_valid, n_res_valid;
    t_res r_res, n_res;

    logic                    slot_free;
    logic                    pop;
    logic [ERR_W-1:0]        mag_l, mag_r;
    logic                    in_l, in_r;
    logic signed [DIF_W-1:0] op_l, op_r;
    logic signed [GAIN_W:0]  gain_op;

    assign slot_free   = !r_res_valid || i_res_ready;
    assign pop         = (r_state == S_IDLE) && i_cmd_valid && slot_free;
    assign o_cmd_pop   = pop;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign mag_l = r_last_l[ERR_W-1] ? ERR_W'(-r_last_l) : ERR_W'(r_last_l);
    assign mag_r = r_last_r[ERR_W-1] ? ERR_W'(-r_last_r) : ERR_W'(r_last_r);
    assign in_l  = (mag_l <= {{(ERR_W-LEEWAY_W){1'b0}}, i_cfg.leeway});
    assign in_r  = (mag_r <= {{(ERR_W-LEEWAY_W){1'b0}}, i_cfg.leeway});

    // one multiplier per side: error times kp first, derivative times kd next
    assign op_l    = (r_state == S_MUL_P) ? {r_e_l[ERR_W-1], r_e_l} : r_d_l;
    assign op_r    = (r_state == S_MUL_P) ? {r_e_r[ERR_W-1], r_e_r} : r_d_r;
    assign gain_op = (r_state == S_MUL_P) ? $signed({1'b0, r_kp}) : $signed({1'b0, r_kd});

    always_comb begin
        n_state     = r_state;
        n_goal_l    = r_goal_l;
        n_goal_r    = r_goal_r;
        n_last_l    = r_last_l;
        n_last_r    = r_last_r;
        n_drive_l   = r_drive_l;
        n_drive_r   = r_drive_r;
        n_kp        = r_kp;
        n_kd        = r_kd;
        n_limit     = r_limit;
        n_elapsed   = r_elapsed;
        n_running   = r_running;
        n_e_l       = r_e_l;
        n_e_r       = r_e_r;
        n_d_l       = r_d_l;
        n_d_r       = r_d_r;
        n_prod_l    = op_l * gain_op;
        n_prod_r    = op_r * gain_op;
        n_acc_l     = r_acc_l;
        n_acc_r     = r_acc_r;
        n_t_l       = sat_power(r_acc_l + r_prod_l);
        n_t_r       = sat_power(r_acc_r + r_prod_r);
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    n_res.power_left  = r_drive_l;
                    n_res.power_right = r_drive_r;
                    n_res.busy_res    = 1'b0;
                    n_res.settled     = 1'b0;
                    n_res.timed_out   = 1'b0;
                    n_e_l = {r_goal_l[POS_W-1], r_goal_l}
                          - {i_cmd.position_left[POS_W-1], i_cmd.position_left};
                    n_e_r = {r_goal_r[POS_W-1], r_goal_r}
                          - {i_cmd.position_right[POS_W-1], i_cmd.position_right};
                    n_d_l = {n_e_l[ERR_W-1], n_e_l} - {r_last_l[ERR_W-1], r_last_l};
                    n_d_r = {n_e_r[ERR_W-1], n_e_r} - {r_last_r[ERR_W-1], r_last_r};
                    priority if (i_cmd.is_start) begin
                        n_goal_l  = i_cmd.target_left;
                        n_goal_r  = i_cmd.target_right;
                        n_kp      = i_cmd.gain_p;
                        n_kd      = i_cmd.gain_d;
                        n_limit   = i_cmd.timeout_periods;
                        n_elapsed = '0;
                        n_last_l  = {i_cmd.target_left[POS_W-1], i_cmd.target_left}
                                  - {i_cmd.position_left[POS_W-1], i_cmd.position_left};
                        n_last_r  = {i_cmd.target_right[POS_W-1], i_cmd.target_right}
                                  - {i_cmd.position_right[POS_W-1], i_cmd.position_right};
                        n_drive_l = '0;
                        n_drive_r = '0;
                        n_running = 1'b1;
                        n_res.power_left  = '0;
                        n_res.power_right = '0;
                        n_res.busy_res    = 1'b1;
                        n_res_valid       = 1'b1;
                    end else if (!r_running) begin
                        n_res_valid = 1'b1;
                    end else if (in_l && in_r) begin
                        n_running     = 1'b0;
                        n_res.settled = 1'b1;
                        n_res_valid   = 1'b1;
                    end else if (r_elapsed >= r_limit) begin
                        n_running       = 1'b0;
                        n_res.timed_out = 1'b1;
                        n_res_valid     = 1'b1;
                    end else begin
                        n_state = S_MUL_P;
                    end
                end
            end
            S_MUL_P: begin
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                n_acc_l = r_prod_l;
                n_acc_r = r_prod_r;
                n_state = S_SAT;
            end
            S_SAT: begin
                n_state = S_DRIVE;
            end
            S_DRIVE: begin
                // result slot was free at pop and nothing else fills it
                n_drive_l = slew(r_drive_l, r_t_l, i_cfg.ramp_step, i_cfg.power_cap);
                n_drive_r = slew(r_drive_r, r_t_r, i_cfg.ramp_step, i_cfg.power_cap);
                n_last_l  = r_e_l;
                n_last_r  = r_e_r;
                n_elapsed = r_elapsed + 1'b1;
                n_res.power_left  = n_drive_l;
                n_res.power_right = n_drive_r;
                n_res.busy_res    = 1'b1;
                n_res.settled     = 1'b0;
                n_res.timed_out   = 1'b0;
                n_res_valid       = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_goal_l    <= '0;
            r_goal_r    <= '0;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_drive_l   <= '0;
            r_drive_r   <= '0;
            r_kp        <= '0;
            r_kd        <= '0;
            r_limit     <= '0;
            r_elapsed   <= '0;
            r_running   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_goal_l    <= n_goal_l;
            r_goal_r    <= n_goal_r;
            r_last_l    <= n_last_l;
            r_last_r    <= n_last_r;
            r_drive_l   <= n_drive_l;
            r_drive_r   <= n_drive_r;
            r_kp        <= n_kp;
            r_kd        <= n_kd;
            r_limit     <= n_limit;
            r_elapsed   <= n_elapsed;
            r_running   <= n_running;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_l    <= n_e_l;
        r_e_r    <= n_e_r;
        r_d_l    <= n_d_l;
        r_d_r    <= n_d_r;
        r_prod_l <= n_prod_l;
        r_prod_r <= n_prod_r;
        r_acc_l  <= n_acc_l;
        r_acc_r  <= n_acc_r;
        r_t_l    <= n_t_l;
        r_t_r    <= n_t_r;
        r_res    <= n_res;
    end

endmodule

// ----- sv/dual_pd_slew_limited_drive_unit.sv -----
// Top level of the dual-side PD drive unit: register port, decode stage, queue, engine.
//
// Usage:
//   s_axis carries start and tick items (tuser bit 0: 0 start, 1 tick). A start loads
//   targets, gains and timeout and returns zero power with busy set. A tick returns
//   the left and right power on m_axis, with busy, settled and timed-out flags.
//   Every item gives exactly one result, in order.
//   The APB port writes and reads ramp step (0x0), power cap (0x4) and leeway (0x8);
//   write it only while no item is in flight.
// An item passes the decode register and the queue; its result is held in the engine's
//   result register. A tick that computes new power first passes the engine's MUL_P,
//   MUL_D, SAT and DRIVE states. One item per cycle for starts and non-computing ticks
//   while m_axis is ready; the engine takes no item until a computing tick is done, as
//   its per-side multiplier forms the kp and kd products in turn before saturation and slew.
// Reset clears the move (idle, powers zero) and loads the register defaults.
// When m_axis stalls, the result holds in its output register while the decode
// stage and the queue keep taking up to three more items before s_axis_tready drops.
module dual_pd_slew_limited_drive_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // target_left, target_right, position_left, position_right, gain_p, gain_d,
    // timeout_periods (from bit 0 up)
    input  logic [dpsld_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [dpsld_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // power_left, power_right (from bit 0 up)
    output logic [dpsld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // busy_res, settled, timed_out (from bit 0 up)
    output logic [dpsld_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dpsld_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dpsld_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dpsld_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import dpsld_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       cfg_wr;
    t_cmd       front_cmd;
    logic       front_valid;
    logic       q_full;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       q_pop;
    t_res       res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step <= RAMP_STEP_RST;
            r_cfg.power_cap <= POWER_CAP_RST;
            r_cfg.leeway    <= LEEWAY_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RAMP_STEP: r_cfg.ramp_step <= pwdata[RAMP_W-1:0];
                REG_POWER_CAP: r_cfg.power_cap <= pwdata[RAMP_W-1:0];
                REG_LEEWAY:    r_cfg.leeway    <= pwdata[LEEWAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RAMP_STEP: prdata = APB_DATA_W'(r_cfg.ramp_step);
            REG_POWER_CAP: prdata = APB_DATA_W'(r_cfg.power_cap);
            REG_LEEWAY:    prdata = APB_DATA_W'(r_cfg.leeway);
            default:       prdata = '0;
        endcase
    end

    dpsld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (!q_full),
        .o_cmd       (front_cmd)
    );

    dpsld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    dpsld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {res.power_right, res.power_left};
    assign m_axis_tuser = {res.timed_out, res.settled, res.busy_res};

endmodule

// ----- sv/dpsld_checker.sv -----
// Port-level checks for the dual-side PD drive unit, bound to the top level.
module dpsld_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [dpsld_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [dpsld_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dpsld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [dpsld_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [dpsld_pkg::APB_ADDR_W-1:0] paddr,
    input logic [dpsld_pkg::APB_DATA_W-1:0] pwdata,
    input logic [dpsld_pkg::APB_DATA_W-1:0] prdata,
    input logic                             pready
);
    import dpsld_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // an ending result is either settled or timed out, never both, and never busy
    a_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            !(m_axis_tuser[1] && m_axis_tuser[2]) &&
            !((m_axis_tuser[1] || m_axis_tuser[2]) && m_axis_tuser[0]))
        else $error("inconsistent end flags");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[PWR_W-1:0] != 8'h80) &&
            (m_axis_tdata[2*PWR_W-1:PWR_W] != 8'h80))
        else $error("power outside symmetric range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind dual_pd_slew_limited_drive_unit dpsld_checker u_dpsld_checker (.*);
